### rtl/adc_frame_deframer_top_macros.svh
// Assertion macros used by the deframer RTL.
`ifndef ADC_FRAME_DEFRAMER_TOP_MACROS_SVH
`define ADC_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ADCFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define ADCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/adcfd_pkg.sv
// Shared types and constants of the ADC frame deframer.
package adcfd_pkg;

  localparam logic [7:0] SYNC_FIRST     = 8'h90;
  localparam logic [7:0] SYNC_SECOND    = 8'hEB;
  localparam logic [7:0] FRAME_MODE_RST = 8'hA0;

  localparam int unsigned CHAN_W    = 9;
  localparam int unsigned ADC_W     = 16;
  localparam int unsigned TRAIL_W   = 4;
  localparam int unsigned M_TDATA_W = 32;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_MODE  = 3'd3,
    PH_LOW   = 3'd4,
    PH_HIGH  = 3'd5,
    PH_TRAIL = 3'd6
  } phase_e;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [ADC_W-1:0]  adc_value;
    logic              last_of_frame;
  } result_t;

endpackage

### rtl/adcfd_in_reg.sv
// Input register stage holding one raw byte from the readout stream.
module adcfd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  output logic       valid_o,
  input  logic       take_i,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### rtl/adcfd_core.sv
// Frame parser: sync hunt, header check, sample assembly and trailer skip.
`include "adc_frame_deframer_top_macros.svh"

module adcfd_core #(
  parameter int unsigned CHANNELS      = 384,
  parameter int unsigned HALF_CHANNELS = 192,
  parameter int unsigned TRAILER_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              take_o,
  input  logic              out_ready_i,
  output logic              res_valid_o,
  output adcfd_pkg::result_t res_o
);

  localparam int unsigned IDX_W  = $clog2(CHANNELS);
  localparam int unsigned NXT_W  = IDX_W + 1;
  localparam int unsigned CH_W   = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;
  // Odd indices map to the high half; only the first ODD_OK of them land in range.
  localparam int unsigned ODD_OK = (CHANNELS > HALF_CHANNELS) ? CHANNELS - HALF_CHANNELS : 0;
  localparam logic [NXT_W-1:0] TWO_ODD  = NXT_W'(2 * ODD_OK);
  localparam logic [NXT_W-1:0] CHAN_LIM = NXT_W'(CHANNELS);
  localparam logic [CH_W-1:0]  HALF_OFS = CH_W'(HALF_CHANNELS);
  localparam logic [adcfd_pkg::TRAIL_W-1:0] TRAIL_INIT = adcfd_pkg::TRAIL_W'(TRAILER_BYTES);

  adcfd_pkg::phase_e phase_q, phase_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic [7:0]                   low_q, low_d;
  logic [adcfd_pkg::TRAIL_W-1:0] trail_q, trail_d;
  logic                         armed_q, armed_d;
  logic [7:0]                   mode_q;

  logic              fire;
  logic [NXT_W-1:0]  inc, nxt;
  logic              last;
  logic [CH_W-1:0]   chan;
  logic [adcfd_pkg::TRAIL_W-1:0] trail_dec;
  logic              at_low, at_high, at_mode, at_trail, mode_hit;

  assign fire   = in_valid_i && out_ready_i;
  assign take_o = fire;

  // Next in-range sample index: skip an odd index whose channel would overflow.
  assign inc  = NXT_W'(idx_q) + NXT_W'(1);
  assign nxt  = (inc[0] && (inc >= TWO_ODD)) ? inc + NXT_W'(1) : inc;
  assign last = nxt >= CHAN_LIM;
  assign chan = CH_W'(idx_q >> 1) + (idx_q[0] ? HALF_OFS : '0);

  assign trail_dec = (trail_q != '0) ? trail_q - adcfd_pkg::TRAIL_W'(1) : trail_q;

  assign at_low   = (phase_q == adcfd_pkg::PH_LOW);
  assign at_high  = (phase_q == adcfd_pkg::PH_HIGH);
  assign at_mode  = (phase_q == adcfd_pkg::PH_MODE);
  assign at_trail = (phase_q == adcfd_pkg::PH_TRAIL);
  assign mode_hit = (in_byte_i == mode_q);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    low_d   = low_q;
    trail_d = trail_q;
    armed_d = armed_q;
    res_valid_o       = 1'b0;
    res_o.channel     = chan[adcfd_pkg::CHAN_W-1:0];
    res_o.adc_value   = {in_byte_i, low_q};
    res_o.last_of_frame = last;
    if (fire) begin
      case (phase_q)
        adcfd_pkg::PH_SYNC2: begin
          phase_d = (in_byte_i == adcfd_pkg::SYNC_SECOND) ? adcfd_pkg::PH_ID
                                                          : adcfd_pkg::PH_HUNT;
        end
        adcfd_pkg::PH_ID: begin
          phase_d = adcfd_pkg::PH_MODE;
        end
        adcfd_pkg::PH_MODE: begin
          if (in_byte_i != mode_q) begin
            phase_d = adcfd_pkg::PH_HUNT;
          end else if (!armed_q) begin
            armed_d = 1'b1;
            phase_d = adcfd_pkg::PH_HUNT;
          end else begin
            idx_d   = '0;
            phase_d = adcfd_pkg::PH_LOW;
          end
        end
        adcfd_pkg::PH_LOW: begin
          low_d   = in_byte_i;
          phase_d = adcfd_pkg::PH_HIGH;
        end
        adcfd_pkg::PH_HIGH: begin
          res_valid_o = 1'b1;
          if (last) begin
            idx_d = '0;
            if (TRAILER_BYTES > 0) begin
              trail_d = TRAIL_INIT;
              phase_d = adcfd_pkg::PH_TRAIL;
            end else begin
              phase_d = adcfd_pkg::PH_HUNT;
            end
          end else begin
            idx_d   = nxt[IDX_W-1:0];
            phase_d = adcfd_pkg::PH_LOW;
          end
        end
        adcfd_pkg::PH_TRAIL: begin
          trail_d = trail_dec;
          if (trail_dec == '0) begin
            phase_d = adcfd_pkg::PH_HUNT;
          end
        end
        default: begin
          phase_d = (in_byte_i == adcfd_pkg::SYNC_FIRST) ? adcfd_pkg::PH_SYNC2
                                                         : adcfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= adcfd_pkg::PH_HUNT;
      idx_q   <= '0;
      low_q   <= '0;
      trail_q <= '0;
      armed_q <= 1'b0;
      mode_q  <= adcfd_pkg::FRAME_MODE_RST;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      low_q   <= low_d;
      trail_q <= trail_d;
      armed_q <= armed_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  `ADCFD_ASSERT_NOW(a_res_only_high, res_valid_o, at_high, "result outside high-byte phase")
  `ADCFD_ASSERT_NEXT(a_low_to_high, fire && at_low, at_high, "low byte not followed by high phase")
  `ADCFD_ASSERT_NEXT(a_arm_on_match, fire && at_mode && mode_hit, armed_q, "matching mode did not arm")
  `ADCFD_ASSERT_NOW(a_trail_nonzero, at_trail, trail_q != '0, "trailer phase with empty count")

endmodule

### rtl/adcfd_out_reg.sv
// Result register stage feeding the master-side stream.
module adcfd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  adcfd_pkg::result_t res_i,
  output logic               valid_o,
  input  logic               ready_i,
  output adcfd_pkg::result_t res_o
);

  logic               valid_q, valid_d;
  adcfd_pkg::result_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### rtl/adc_frame_deframer_top.sv
// Top level of the ADC frame deframer.
// Takes one raw byte per cycle on the slave stream and emits one 16-bit ADC
// sample word for every two payload bytes of a decoded frame; a byte can be
// accepted in every cycle while the master side keeps up. Each byte passes
// an input register and then the result register; a stalled master side
// holds the result register and, behind it, the input register. The block
// hunts for the sync pair 0x90 0xEB, skips the ID byte and checks the mode
// byte against frame_mode (reset 0xA0; the user must see that it is written
// on the cfg channel only while the stream is idle, unenforced by the block).
// The first matching frame only arms the block; later ones deliver a sample
// for each index below CHANNELS whose channel exists, with its de-interleaved
// channel number (even index to the low half, odd index from HALF_CHANNELS
// up) and tlast on the final sample, then TRAILER_BYTES bytes are skipped.
module adc_frame_deframer_top #(
  parameter int unsigned CHANNELS      = 384,
  parameter int unsigned HALF_CHANNELS = 192,
  parameter int unsigned TRAILER_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // frame_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [8:0] channel, [24:9] adc_value, rest zero
  output logic        m_axis_tlast    // last_of_frame
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               take;
  logic               out_ready;
  logic               res_valid;
  adcfd_pkg::result_t res;
  adcfd_pkg::result_t res_out;

  assign cfg_ready_o = 1'b1;

  adcfd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .valid_o (in_valid),
    .take_i  (take),
    .byte_o  (in_byte)
  );

  adcfd_core #(
    .CHANNELS      (CHANNELS),
    .HALF_CHANNELS (HALF_CHANNELS),
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid),
    .in_byte_i   (in_byte),
    .take_o      (take),
    .out_ready_i (out_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  adcfd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .ready_o (out_ready),
    .res_i   (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {
    (adcfd_pkg::M_TDATA_W - adcfd_pkg::CHAN_W - adcfd_pkg::ADC_W)'(0),
    res_out.adc_value,
    res_out.channel
  };
  assign m_axis_tlast = res_out.last_of_frame;

endmodule

### tb/adc_frame_deframer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ADC frame deframer: byte stream in, sample words out.
module adc_frame_deframer_top_tb;

  localparam int unsigned CHANNELS      = 384;
  localparam int unsigned HALF_CHANNELS = 192;
  localparam int unsigned TRAILER_BYTES = 8;
  localparam int unsigned N_DIR         = 25;
  localparam int unsigned PHASE_BYTES   = 425;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned VAL_LO        = adcfd_pkg::CHAN_W;
  localparam int unsigned VAL_HI        = adcfd_pkg::CHAN_W + adcfd_pkg::ADC_W - 1;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               typed;
    adcfd_pkg::result_t want;
  } dir_row_t;

  // Directed bytes; rows marked typed carry the sample word they must produce.
  localparam dir_row_t [0:N_DIR-1] DIR_TAB = {
    {8'h00, 1'b0, 26'd0},
    {8'hFF, 1'b0, 26'd0},
    {8'h90, 1'b0, 26'd0},
    {8'h90, 1'b0, 26'd0},  // second byte of the pair is not 0xEB
    {8'hEB, 1'b0, 26'd0},  // lone 0xEB while hunting
    {8'h90, 1'b0, 26'd0},
    {8'hEB, 1'b0, 26'd0},
    {8'h12, 1'b0, 26'd0},
    {8'h55, 1'b0, 26'd0},  // mode mismatch drops the frame
    {8'h90, 1'b0, 26'd0},
    {8'hEB, 1'b0, 26'd0},
    {8'hFF, 1'b0, 26'd0},
    {8'hA0, 1'b0, 26'd0},  // first matching frame only arms
    {8'h90, 1'b0, 26'd0},
    {8'hEB, 1'b0, 26'd0},
    {8'h00, 1'b0, 26'd0},
    {8'hA0, 1'b0, 26'd0},
    {8'h00, 1'b0, 26'd0},
    {8'h00, 1'b1, 9'd0, 16'h0000, 1'b0},
    {8'hFF, 1'b0, 26'd0},
    {8'hFF, 1'b1, 9'd192, 16'hFFFF, 1'b0},
    {8'h34, 1'b0, 26'd0},
    {8'h12, 1'b1, 9'd1, 16'h1234, 1'b0},
    {8'hCD, 1'b0, 26'd0},
    {8'hAB, 1'b0, 26'd0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned src_idle   = 0;
  int unsigned sink_stall = 0;
  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;

  adcfd_pkg::result_t sample_q [$];
  logic [7:0]         stream_q [$];

  // Predictor state.
  adcfd_pkg::phase_e dec_phase = adcfd_pkg::PH_HUNT;
  int unsigned       dec_index = 0;
  logic [7:0]        dec_low   = 8'h00;
  logic [3:0]        dec_trail = 4'h0;
  logic              dec_armed = 1'b0;
  logic [7:0]        dec_mode  = adcfd_pkg::FRAME_MODE_RST;

  adc_frame_deframer_top #(
    .CHANNELS     (CHANNELS),
    .HALF_CHANNELS(HALF_CHANNELS),
    .TRAILER_BYTES(TRAILER_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("adc_frame_deframer_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall);
  end

  function automatic int unsigned chan_of(int unsigned i);
    return (i % 2) * HALF_CHANNELS + i / 2;
  endfunction

  // First sample index at or after i whose channel exists.
  function automatic int unsigned next_in_range(int unsigned i);
    while (i < CHANNELS && chan_of(i) >= CHANNELS) i++;
    return i;
  endfunction

  task automatic enter_trailer();
    if (TRAILER_BYTES > 0) begin
      dec_trail = 4'(TRAILER_BYTES);
      dec_phase = adcfd_pkg::PH_TRAIL;
    end else begin
      dec_phase = adcfd_pkg::PH_HUNT;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output logic got,
                              output adcfd_pkg::result_t smp);
    int unsigned nxt;
    got = 1'b0;
    smp = '0;
    case (dec_phase)
      adcfd_pkg::PH_SYNC2: begin
        dec_phase = (b == adcfd_pkg::SYNC_SECOND) ? adcfd_pkg::PH_ID : adcfd_pkg::PH_HUNT;
      end
      adcfd_pkg::PH_ID: dec_phase = adcfd_pkg::PH_MODE;
      adcfd_pkg::PH_MODE: begin
        if (b != dec_mode) begin
          dec_phase = adcfd_pkg::PH_HUNT;
        end else if (!dec_armed) begin
          dec_armed = 1'b1;
          dec_phase = adcfd_pkg::PH_HUNT;
        end else begin
          dec_index = next_in_range(0);
          if (dec_index >= CHANNELS) enter_trailer();
          else dec_phase = adcfd_pkg::PH_LOW;
        end
      end
      adcfd_pkg::PH_LOW: begin
        dec_low   = b;
        dec_phase = adcfd_pkg::PH_HIGH;
      end
      adcfd_pkg::PH_HIGH: begin
        nxt               = next_in_range(dec_index + 1);
        got               = 1'b1;
        smp.channel       = adcfd_pkg::CHAN_W'(chan_of(dec_index));
        smp.adc_value     = {b, dec_low};
        smp.last_of_frame = (nxt >= CHANNELS);
        if (nxt >= CHANNELS) begin
          dec_index = 0;
          enter_trailer();
        end else begin
          dec_index = nxt;
          dec_phase = adcfd_pkg::PH_LOW;
        end
      end
      adcfd_pkg::PH_TRAIL: begin
        if (dec_trail != 4'h0) dec_trail--;
        if (dec_trail == 4'h0) dec_phase = adcfd_pkg::PH_HUNT;
      end
      default: begin
        dec_phase = (b == adcfd_pkg::SYNC_FIRST) ? adcfd_pkg::PH_SYNC2 : adcfd_pkg::PH_HUNT;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input adcfd_pkg::result_t want);
    logic               hit;
    logic               got;
    adcfd_pkg::result_t smp;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(negedge clk_i);
      hit = s_axis_tready;
      @(posedge clk_i);
    end while (!hit);
    deframe_byte(b, got, smp);
    if (typed) sample_q.push_back(want);
    else if (got) sample_q.push_back(smp);
  endtask

  task automatic await_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sample_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [7:0] m);
    logic hit;
    await_outputs();
    // A header or trailer byte may still sit in the pipeline with no word to show for it.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do begin
      @(negedge clk_i);
      hit = cfg_ready_o;
      @(posedge clk_i);
    end while (!hit);
    cfg_valid_i <= 1'b0;
    dec_mode = m;
  endtask

  always @(negedge clk_i) begin : sample_check
    adcfd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sample_q.size() == 0) begin
        $error("unexpected sample word: tdata %h, tlast %b", m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        want = sample_q.pop_front();
        if (m_axis_tdata[adcfd_pkg::CHAN_W-1:0] !== want.channel) begin
          $error("channel: expected %0d, got %0d", want.channel,
                 m_axis_tdata[adcfd_pkg::CHAN_W-1:0]);
          err_cnt++;
        end
        if (m_axis_tdata[VAL_HI:VAL_LO] !== want.adc_value) begin
          $error("adc_value: expected %h, got %h", want.adc_value,
                 m_axis_tdata[VAL_HI:VAL_LO]);
          err_cnt++;
        end
        if (m_axis_tlast !== want.last_of_frame) begin
          $error("last_of_frame: expected %b, got %b", want.last_of_frame, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  m;
    logic [7:0]  fill;
    int unsigned pick;
    int unsigned len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      send_byte(DIR_TAB[i].data_byte, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    // The random stream runs on across phases, so a phase can start mid-frame.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: m = 8'hFF;
        1: m = 8'h00;
        2: m = 8'($urandom);
        default: m = adcfd_pkg::SYNC_FIRST;
      endcase
      write_mode(m);
      src_idle   = (ph == 1) ? 78 : (ph == 3) ? 8 : 0;
      sink_stall = (ph == 2) ? 78 : (ph == 3) ? 8 : 0;
      for (int n = 0; n < PHASE_BYTES; n++) begin
        if (n == PHASE_BYTES / 2) await_outputs();
        if (stream_q.size() == 0) begin
          pick = $urandom_range(99);
          if (pick < 35) begin
            // Well-formed frame, now and then cut short so the next bytes land as samples.
            stream_q.push_back(adcfd_pkg::SYNC_FIRST);
            stream_q.push_back(adcfd_pkg::SYNC_SECOND);
            stream_q.push_back(8'($urandom));
            stream_q.push_back(dec_mode);
            len = ($urandom_range(4) == 0) ? $urandom_range(2 * CHANNELS - 1) : 2 * CHANNELS;
            repeat (len) stream_q.push_back(8'($urandom));
            repeat (TRAILER_BYTES) stream_q.push_back(8'($urandom));
          end else if (pick < 50) begin
            do fill = 8'($urandom); while (fill == dec_mode);
            stream_q.push_back(adcfd_pkg::SYNC_FIRST);
            stream_q.push_back(adcfd_pkg::SYNC_SECOND);
            stream_q.push_back(8'($urandom));
            stream_q.push_back(fill);
          end else if (pick < 65) begin
            fill = ($urandom_range(1) == 0) ? adcfd_pkg::SYNC_FIRST : 8'($urandom);
            if (fill == adcfd_pkg::SYNC_SECOND) fill = 8'h00;
            stream_q.push_back(adcfd_pkg::SYNC_FIRST);
            stream_q.push_back(fill);
          end else if (pick < 72) begin
            stream_q.push_back(adcfd_pkg::SYNC_FIRST);
            stream_q.push_back(adcfd_pkg::SYNC_SECOND);
          end else begin
            repeat ($urandom_range(1, 16)) begin
              stream_q.push_back(($urandom_range(3) == 0) ? adcfd_pkg::SYNC_FIRST
                                                          : 8'($urandom));
            end
          end
        end
        send_byte(stream_q.pop_front(), 1'b0, '0);
      end
    end

    await_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("adc_frame_deframer_top_tb: clean");
    end else begin
      $display("adc_frame_deframer_top_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/adcfd_pkg.sv
rtl/adcfd_in_reg.sv
rtl/adcfd_core.sv
rtl/adcfd_out_reg.sv
rtl/adc_frame_deframer_top.sv
tb/adc_frame_deframer_top_tb.sv
